>>> sv/ray_box_intersection_top_macros.svh
// Assertion macros used by the ray/box intersection top level.
`ifndef RAY_BOX_INTERSECTION_TOP_MACROS_SVH
`define RAY_BOX_INTERSECTION_TOP_MACROS_SVH
`ifndef SYNTHESIS
// checked property, masked while reset is asserted
`define RBI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also during reset
`define RBI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBI_ASSERT(lbl, clk, rst_n, prop, msg)
`define RBI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> sv/rbi_pkg.sv
// Types and constants for the ray/box intersection block.
`default_nettype none
package rbi_pkg;
    localparam int COORD_W = 32;
    localparam int T_W     = 48;
    localparam int SPLIT   = 24;
    localparam int HI_W    = T_W - SPLIT;
    localparam int PROD_W  = 56;
    localparam int OFF_W   = 41;
    localparam int PT_W    = 43;
    localparam int NAXES   = 3;

    localparam logic [T_W-1:0]   T_LIMIT   = 48'h7FFF_FFFF_FFFF;
    localparam logic [OFF_W-1:0] OFF_LIMIT = 41'h100_0000_0000;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] org;
        logic signed [COORD_W-1:0] dir;
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        logic signed [COORD_W-1:0] cand;
        logic                      outside;
        logic                      tvalid;
        logic                      neg;
    } axis_side_t;

    typedef struct packed {
        logic                      hit;
        logic                      origin_inside;
        axis_t                     entry_axis;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } res_t;
endpackage
`default_nettype wire

>>> sv/rbi_lane.sv
// One axis lane: slab classification and pipelined slab distance division.
`default_nettype none
module rbi_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] org,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] dir,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] lo,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] hi,
    output logic                                    out_valid,
    output logic signed [rbi_pkg::T_W-1:0]          out_t,
    output rbi_pkg::axis_side_t                     out_side
);
    import rbi_pkg::*;

    localparam int NB = COORD_W + FRAC_BITS;
    localparam int QW = (NB + 1 > T_W) ? NB + 1 : T_W;

    logic [NB:0]         vld_reg;
    logic                out_valid_reg;
    logic [NB-1:0]       num_reg [NB+1];
    logic [NB-1:0]       q_reg   [NB+1];
    logic [COORD_W-1:0]  rem_reg [NB+1];
    logic [COORD_W-1:0]  dm_reg  [NB+1];
    axis_side_t          side_reg[NB+1];
    logic signed [T_W-1:0] t_reg;
    axis_side_t          oside_reg;

    // setup
    logic               below, above;
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]   ndiff;
    logic [COORD_W-1:0] absd, dmag;
    axis_side_t         side_next;

    always_comb begin
        below = org < lo;
        above = org > hi;
        side_next.org  = org;
        side_next.dir  = dir;
        side_next.lo   = lo;
        side_next.hi   = hi;
        side_next.cand = below ? lo : (above ? hi : '0);
        diff  = {side_next.cand[COORD_W-1], side_next.cand} - {org[COORD_W-1], org};
        ndiff = -diff;
        absd  = diff[COORD_W] ? ndiff[COORD_W-1:0] : diff[COORD_W-1:0];
        dmag  = dir[COORD_W-1] ? (~dir + 32'd1) : dir;
        side_next.outside = below | above;
        side_next.tvalid  = (below | above) && (dir != '0);
        side_next.neg     = diff[COORD_W] ^ dir[COORD_W-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0]  <= {absd, {FRAC_BITS{1'b0}}};
            q_reg[0]    <= '0;
            rem_reg[0]  <= '0;
            dm_reg[0]   <= dmag;
            side_reg[0] <= side_next;
        end
    end

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < NB; k++) begin : g_div
        logic [COORD_W:0]   rsh, rsub;
        logic               ge;
        logic [COORD_W-1:0] rem_next;

        always_comb begin
            rsh      = {rem_reg[k], num_reg[k][NB-1]};
            rsub     = rsh - {1'b0, dm_reg[k]};
            ge       = rsh >= {1'b0, dm_reg[k]};
            rem_next = ge ? rsub[COORD_W-1:0] : rsh[COORD_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k+1]  <= {num_reg[k][NB-2:0], 1'b0};
                q_reg[k+1]    <= {q_reg[k][NB-2:0], ge};
                rem_reg[k+1]  <= rem_next;
                dm_reg[k+1]   <= dm_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // rounding toward minus infinity, saturation
    logic [QW-1:0]         qx;
    logic [T_W-1:0]        qmag;
    logic signed [T_W-1:0] t_next;

    always_comb begin
        qx   = QW'(q_reg[NB]) + QW'(side_reg[NB].neg && (rem_reg[NB] != '0));
        qmag = (qx > QW'(T_LIMIT)) ? T_LIMIT : qx[T_W-1:0];
        if (!side_reg[NB].tvalid) begin
            t_next = -($signed(T_W'(1)) <<< FRAC_BITS);
        end else if (side_reg[NB].neg) begin
            t_next = -$signed(qmag);
        end else begin
            t_next = $signed(qmag);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg     <= t_next;
            oside_reg <= side_reg[NB];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[NB-1:0], in_valid};
            out_valid_reg <= vld_reg[NB];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_t     = t_reg;
    assign out_side  = oside_reg;
endmodule
`default_nettype wire

>>> sv/rbi_merge.sv
// Merge stage: entry plane selection, point on the other axes, box check.
`default_nettype none
module rbi_merge #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic [rbi_pkg::NAXES-1:0]      in_valid,
    input  wire logic signed [rbi_pkg::T_W-1:0] in_t    [rbi_pkg::NAXES],
    input  wire rbi_pkg::axis_side_t            in_side [rbi_pkg::NAXES],
    output logic                                out_valid,
    output rbi_pkg::res_t                       out_res
);
    import rbi_pkg::*;

    localparam int S   = SPLIT - FRAC_BITS;
    localparam int QCW = 50;

    // stage A: winner
    logic                  va_reg, vb_reg, vc_reg, vd_reg;
    logic signed [T_W-1:0] tb_reg;
    axis_t                 besta_reg, bestb_reg, bestc_reg, bestd_reg;
    logic                  insa_reg, insb_reg, insc_reg, insd_reg;
    logic                  missa_reg, missb_reg, missc_reg, missd_reg;
    axis_side_t            sa_reg[NAXES], sb_reg[NAXES], sc_reg[NAXES], sd_reg[NAXES];

    axis_t                 b1, best_next;
    logic signed [T_W-1:0] t1, tbest;

    always_comb begin
        b1        = (in_t[0] < in_t[1]) ? AXIS_Y : AXIS_X;
        t1        = (in_t[0] < in_t[1]) ? in_t[1] : in_t[0];
        best_next = (t1 < in_t[2]) ? AXIS_Z : b1;
        tbest     = (t1 < in_t[2]) ? in_t[2] : t1;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tb_reg    <= tbest;
            besta_reg <= best_next;
            insa_reg  <= !(in_side[0].outside | in_side[1].outside | in_side[2].outside);
            missa_reg <= tbest < 0;
            sa_reg    <= in_side;
        end
    end

    // stage B: split products
    logic [PROD_W-1:0] a_reg[NAXES], b_reg[NAXES];
    // stage C: clamped offsets
    logic [OFF_W-1:0]  q_reg[NAXES];
    logic              r_reg[NAXES];
    // stage D: points
    logic signed [PT_W-1:0] pt_reg[NAXES];

    for (genvar k = 0; k < NAXES; k++) begin : g_ax
        logic [COORD_W-1:0] dm;
        logic [PROD_W-1:0]  as;
        logic [QCW-1:0]     qf;
        logic               over;
        logic [OFF_W-1:0]   qn;
        logic               rn;
        logic signed [PT_W-1:0] orgx;

        always_comb begin
            dm   = sa_reg[k].dir[COORD_W-1] ? (~sa_reg[k].dir + 32'd1) : sa_reg[k].dir;
            as   = a_reg[k] << S;
            over = a_reg[k] > PROD_W'(OFF_LIMIT >> S);
            qf   = QCW'(as) + QCW'(b_reg[k] >> FRAC_BITS);
            if (over || qf > QCW'(OFF_LIMIT)) begin
                qn = OFF_LIMIT;
                rn = 1'b0;
            end else begin
                qn = qf[OFF_W-1:0];
                rn = b_reg[k][FRAC_BITS-1:0] != '0;
            end
            orgx = PT_W'(sc_reg[k].org);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[k]  <= PROD_W'(tb_reg[T_W-1:SPLIT]) * PROD_W'(dm);
                b_reg[k]  <= PROD_W'(tb_reg[SPLIT-1:0]) * PROD_W'(dm);
                q_reg[k]  <= qn;
                r_reg[k]  <= rn;
                pt_reg[k] <= sc_reg[k].dir[COORD_W-1]
                           ? orgx - $signed(PT_W'(q_reg[k])) - $signed(PT_W'(r_reg[k]))
                           : orgx + $signed(PT_W'(q_reg[k]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bestb_reg <= besta_reg;
            insb_reg  <= insa_reg;
            missb_reg <= missa_reg;
            sb_reg    <= sa_reg;
            bestc_reg <= bestb_reg;
            insc_reg  <= insb_reg;
            missc_reg <= missb_reg;
            sc_reg    <= sb_reg;
            bestd_reg <= bestc_reg;
            insd_reg  <= insc_reg;
            missd_reg <= missc_reg;
            sd_reg    <= sc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            va_reg <= &in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    // final decision
    logic [NAXES-1:0]          oob;
    logic signed [COORD_W-1:0] pnt[NAXES];

    always_comb begin
        for (int k = 0; k < NAXES; k++) begin
            oob[k] = (axis_t'(k) != bestd_reg)
                  && ((pt_reg[k] < PT_W'(sd_reg[k].lo)) || (pt_reg[k] > PT_W'(sd_reg[k].hi)));
            pnt[k] = (axis_t'(k) == bestd_reg) ? sd_reg[k].cand : pt_reg[k][COORD_W-1:0];
        end
        out_res = '0;
        if (insd_reg) begin
            out_res.hit           = 1'b1;
            out_res.origin_inside = 1'b1;
            out_res.entry_axis    = AXIS_X;
            out_res.point_x       = sd_reg[0].org;
            out_res.point_y       = sd_reg[1].org;
            out_res.point_z       = sd_reg[2].org;
        end else if (!missd_reg && oob == '0) begin
            out_res.hit        = 1'b1;
            out_res.entry_axis = bestd_reg;
            out_res.point_x    = pnt[0];
            out_res.point_y    = pnt[1];
            out_res.point_z    = pnt[2];
        end
    end

    assign out_valid = vd_reg;
endmodule
`default_nettype wire

>>> sv/ray_box_intersection_top.sv
// Top level of the ray / axis-aligned box intersection block.
// Slab test (Woo) on signed fixed-point rays, FRAC_BITS fraction bits. Three
// axis lanes run side by side, each with a restoring divider of one quotient
// bit per stage, then a merge stage picks the entry plane, forms the point on
// the other axes with split 24x32 products and checks it against the box.
// A new word is taken every cycle while s_ready is high. The whole pipeline
// advances together; a two-word skid stage at the output lets one more word
// enter while a result waits, after which s_ready drops until the result is
// taken.
`default_nettype none
`include "ray_box_intersection_top_macros.svh"
module ray_box_intersection_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] s_origin_x,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] s_origin_y,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] s_origin_z,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] s_dir_x,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] s_dir_y,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] s_dir_z,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] s_box_min_x,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] s_box_min_y,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] s_box_min_z,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] s_box_max_x,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] s_box_max_y,
    input  wire logic signed [rbi_pkg::COORD_W-1:0] s_box_max_z,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_hit,
    output logic                                    m_origin_inside,
    output logic [1:0]                              m_entry_axis,
    output logic signed [rbi_pkg::COORD_W-1:0]      m_point_x,
    output logic signed [rbi_pkg::COORD_W-1:0]      m_point_y,
    output logic signed [rbi_pkg::COORD_W-1:0]      m_point_z
);
    import rbi_pkg::*;

    logic                  en;
    logic [NAXES-1:0]      lane_valid;
    logic signed [T_W-1:0] lane_t   [NAXES];
    axis_side_t            lane_side[NAXES];
    logic                  mrg_valid;
    res_t                  mrg_res;

    // output skid: main word plus one spare
    logic out_valid_reg, spare_valid_reg;
    res_t out_reg, spare_reg;
    logic push, pop;

    // pipeline moves while the skid spare slot is free
    assign en      = s_ready;
    assign s_ready = !spare_valid_reg;

    rbi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid),
        .org(s_origin_x), .dir(s_dir_x), .lo(s_box_min_x), .hi(s_box_max_x),
        .out_valid(lane_valid[0]), .out_t(lane_t[0]), .out_side(lane_side[0])
    );

    rbi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid),
        .org(s_origin_y), .dir(s_dir_y), .lo(s_box_min_y), .hi(s_box_max_y),
        .out_valid(lane_valid[1]), .out_t(lane_t[1]), .out_side(lane_side[1])
    );

    rbi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid),
        .org(s_origin_z), .dir(s_dir_z), .lo(s_box_min_z), .hi(s_box_max_z),
        .out_valid(lane_valid[2]), .out_t(lane_t[2]), .out_side(lane_side[2])
    );

    rbi_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(lane_valid),
        .in_t(lane_t), .in_side(lane_side),
        .out_valid(mrg_valid), .out_res(mrg_res)
    );

    assign push = en && mrg_valid;
    assign pop  = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else if (spare_valid_reg) begin
            if (pop) begin
                spare_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                spare_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (spare_valid_reg) begin
            if (pop) begin
                out_reg <= spare_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                spare_reg <= mrg_res;
            end else begin
                out_reg <= mrg_res;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_hit           = out_reg.hit;
    assign m_origin_inside = out_reg.origin_inside;
    assign m_entry_axis    = out_reg.entry_axis;
    assign m_point_x       = out_reg.point_x;
    assign m_point_y       = out_reg.point_y;
    assign m_point_z       = out_reg.point_z;

    `RBI_ASSERT_ALWAYS(a_spare_needs_main, aclk, spare_valid_reg |-> out_valid_reg, "spare word without main word")
    `RBI_ASSERT(a_full_blocks_input, aclk, aresetn, spare_valid_reg |-> !s_ready, "input taken with skid full")
    `RBI_ASSERT(a_miss_clean, aclk, aresetn, (m_valid && !m_hit) |-> (!m_origin_inside && m_entry_axis == AXIS_X && m_point_x == 0 && m_point_y == 0 && m_point_z == 0), "miss word not cleared")
    `RBI_ASSERT(a_inside_hits, aclk, aresetn, (m_valid && m_origin_inside) |-> (m_hit && m_entry_axis == AXIS_X), "inside word malformed")
    `RBI_ASSERT(a_axis_code, aclk, aresetn, m_valid |-> (m_entry_axis != 2'd3), "bad entry axis")
endmodule
`default_nettype wire
